// ===== rtl/kahn_topological_order_unit_macros.svh =====
// Assertion macros used by the sort unit's sequencer module.
`ifndef KAHN_TOPOLOGICAL_ORDER_UNIT_MACROS_SVH
`define KAHN_TOPOLOGICAL_ORDER_UNIT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define KTO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define KTO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/kto_pkg.sv =====
// Shared constants of the topological sort unit.
package kto_pkg;
  localparam int MAX_NODES_DEF = 64;
  localparam int MAX_EDGES_DEF = 1024;
  localparam int NODE_W = 6;
  localparam int CNT_W = 7;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-1:0] REG_NODE_COUNT = 3'd0;
  localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 7'd64;
endpackage

// ===== rtl/kto_loader.sv =====
// Edge loader: range check, fill count and the edge memory.
module kto_loader #(
  parameter int MAX_EDGES = kto_pkg::MAX_EDGES_DEF,
  parameter int EC_W = $clog2(MAX_EDGES + 1),
  parameter int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [kto_pkg::NODE_W-1:0] source_node,
  input  logic [kto_pkg::NODE_W-1:0] target_node,
  input  logic                      edge_present,
  input  logic [kto_pkg::CNT_W-1:0] node_lim,
  input  logic                      clear,
  input  logic [EA_W-1:0]           rd_addr,
  output logic [EC_W-1:0]           edge_total,
  output logic [kto_pkg::NODE_W-1:0] rd_src,
  output logic [kto_pkg::NODE_W-1:0] rd_dst
);
  logic [2*kto_pkg::NODE_W-1:0] mem [MAX_EDGES];
  logic wr;

  assign wr = accept && edge_present
              && ({1'b0, source_node} < node_lim)
              && ({1'b0, target_node} < node_lim)
              && (edge_total < EC_W'(MAX_EDGES));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      edge_total <= '0;
    end else if (wr) begin
      edge_total <= edge_total + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[edge_total[EA_W-1:0]] <= {source_node, target_node};
    end
    {rd_src, rd_dst} <= mem[rd_addr];
  end
endmodule

// ===== rtl/kto_sorter.sv =====
// Sort sequencer with in-degree and ready-queue memories and the output register.
`include "kahn_topological_order_unit_macros.svh"
module kto_sorter #(
  parameter int MAX_NODES = kto_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = kto_pkg::MAX_EDGES_DEF,
  parameter int EC_W = $clog2(MAX_EDGES + 1),
  parameter int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       last_in,
  input  logic [kto_pkg::CNT_W-1:0]  node_lim,
  input  logic [EC_W-1:0]            edge_total,
  input  logic [kto_pkg::NODE_W-1:0] rd_src,
  input  logic [kto_pkg::NODE_W-1:0] rd_dst,
  output logic [EA_W-1:0]            rd_addr,
  output logic                       clear,
  output logic                       loading,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [kto_pkg::NODE_W-1:0] order_node,
  output logic                       cycle_found,
  output logic                       last_result
);
  localparam int NW = kto_pkg::NODE_W;
  localparam int CW = kto_pkg::CNT_W;
  localparam logic [3:0] S_LOAD = 4'd0, S_DRD = 4'd1, S_DIX = 4'd2, S_DWR = 4'd3,
                         S_SRD = 4'd4, S_SCHK = 4'd5, S_QRD = 4'd6, S_QGET = 4'd7,
                         S_ERD = 4'd8, S_EIX = 4'd9, S_EWR = 4'd10, S_ORD = 4'd11,
                         S_OLD = 4'd12, S_OWAIT = 4'd13;

  logic [3:0] state;
  logic [EC_W-1:0] eidx;
  logic [CW-1:0] nidx, head, tail;
  logic [NW-1:0] x, cur_dst;
  logic cur_ok;
  logic [MAX_NODES-1:0] vld;
  logic vld_q;
  logic [EC_W-1:0] deg_mem [MAX_NODES];
  logic [EC_W-1:0] deg_q, deg_val, deg_wd;
  logic [NW-1:0] deg_ra;
  logic deg_we;
  logic [NW-1:0] q_mem [MAX_NODES];
  logic [NW-1:0] q_q, q_wd, q_ra;
  logic q_we;

  assign deg_val = vld_q ? deg_q : '0;
  assign rd_addr = eidx[EA_W-1:0];
  assign loading = (state == S_LOAD);
  assign clear = (state == S_OWAIT) && out_valid && !out_stall && last_result;

  always_comb begin
    deg_ra = cur_dst;
    if (state == S_SRD) begin
      deg_ra = nidx[NW-1:0];
    end else if (state == S_DIX || state == S_EIX) begin
      deg_ra = rd_dst;
    end
    q_ra = (state == S_ORD) ? nidx[NW-1:0] : head[NW-1:0];
    deg_we = 1'b0;
    deg_wd = deg_val + 1'b1;
    q_we = 1'b0;
    q_wd = cur_dst;
    if (state == S_DWR && cur_ok) begin
      deg_we = 1'b1;
    end
    if (state == S_EWR && cur_ok && deg_val != '0) begin
      deg_we = 1'b1;
      deg_wd = deg_val - 1'b1;
      q_we = (deg_val == EC_W'(1)) && (tail < CW'(MAX_NODES));
    end
    if (state == S_SCHK) begin
      q_wd = nidx[NW-1:0];
      q_we = (deg_val == '0) && (tail < CW'(MAX_NODES));
    end
  end

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[cur_dst] <= deg_wd;
    end
    deg_q <= deg_mem[deg_ra];
    vld_q <= vld[deg_ra];
    if (q_we) begin
      q_mem[tail[NW-1:0]] <= q_wd;
    end
    q_q <= q_mem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      eidx <= '0;
      nidx <= '0;
      head <= '0;
      tail <= '0;
      vld <= '0;
      out_valid <= 1'b0;
    end else begin
      if (deg_we) begin
        vld[cur_dst] <= 1'b1;
      end
      if (q_we) begin
        tail <= tail + 1'b1;
      end
      unique case (state)
        S_LOAD: begin
          if (last_in) begin
            vld <= '0;
            eidx <= '0;
            head <= '0;
            tail <= '0;
            state <= S_DRD;
          end
        end
        S_DRD: begin
          if (eidx == edge_total) begin
            nidx <= '0;
            state <= S_SRD;
          end else begin
            state <= S_DIX;
          end
        end
        S_DIX: begin
          cur_dst <= rd_dst;
          cur_ok <= ({1'b0, rd_src} < node_lim) && ({1'b0, rd_dst} < node_lim);
          state <= S_DWR;
        end
        S_DWR: begin
          eidx <= eidx + 1'b1;
          state <= S_DRD;
        end
        S_SRD: begin
          cur_dst <= nidx[NW-1:0];
          state <= (nidx == node_lim) ? S_QRD : S_SCHK;
        end
        S_SCHK: begin
          nidx <= nidx + 1'b1;
          state <= S_SRD;
        end
        S_QRD: begin
          if (head != tail) begin
            state <= S_QGET;
          end else if (tail == node_lim) begin
            nidx <= '0;
            state <= S_ORD;
          end else begin
            order_node <= '0;
            cycle_found <= 1'b1;
            last_result <= 1'b1;
            out_valid <= 1'b1;
            state <= S_OWAIT;
          end
        end
        S_QGET: begin
          x <= q_q;
          head <= head + 1'b1;
          eidx <= '0;
          state <= S_ERD;
        end
        S_ERD: begin
          state <= (eidx == edge_total) ? S_QRD : S_EIX;
        end
        S_EIX: begin
          cur_dst <= rd_dst;
          cur_ok <= (rd_src == x) && ({1'b0, rd_dst} < node_lim);
          state <= S_EWR;
        end
        S_EWR: begin
          eidx <= eidx + 1'b1;
          state <= S_ERD;
        end
        S_ORD: begin
          state <= S_OLD;
        end
        S_OLD: begin
          order_node <= q_q;
          cycle_found <= 1'b0;
          last_result <= (nidx == node_lim - 1'b1);
          out_valid <= 1'b1;
          state <= S_OWAIT;
        end
        S_OWAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_result) begin
              state <= S_LOAD;
            end else begin
              nidx <= nidx + 1'b1;
              state <= S_ORD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  `KTO_ASSERT_NOW(a_tail_bound, 1'b1, tail <= CW'(MAX_NODES), "queue tail past capacity")
  `KTO_ASSERT_NOW(a_head_tail, 1'b1, head <= tail, "queue head past tail")
  `KTO_ASSERT_NOW(a_out_state, out_valid, state == S_OWAIT, "word shown outside output wait")
  `KTO_ASSERT_NXT(a_start, state == S_LOAD && last_in, state == S_DRD, "sort did not start")
endmodule

// ===== rtl/kahn_topological_order_unit.sv =====
// After the last word: an edge memory scan counts in-degrees, a node pass seeds the queue,
// then each dequeued node scans every stored edge (edge memory scan), then results leave.
// Throughput: one edge word per cycle while loading; input stalls during sort and output.
// Each output word is read from the queue memory only after the previous word is taken.
// Reset: synchronous, clears control state and sets node_count to 64; memories hold no reset.
module kahn_topological_order_unit #(
  parameter int MAX_NODES = kto_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = kto_pkg::MAX_EDGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kto_pkg::ADDR_W-1:0]   paddr,
  input  logic [kto_pkg::DATA_W-1:0]   pwdata,
  output logic [kto_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [kto_pkg::NODE_W-1:0]   source_node,
  input  logic [kto_pkg::NODE_W-1:0]   target_node,
  input  logic                         edge_present,
  input  logic                         last_edge,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [kto_pkg::NODE_W-1:0]   order_node,
  output logic                         cycle_found,
  output logic                         last_result
);
  localparam int EC_W = $clog2(MAX_EDGES + 1);
  localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = kto_pkg::CNT_W;

  logic [CW-1:0] node_count, node_lim;
  logic accept, clear, loading;
  logic [EC_W-1:0] edge_total;
  logic [EA_W-1:0] rd_addr;
  logic [kto_pkg::NODE_W-1:0] rd_src, rd_dst;

  assign pready = 1'b1;
  assign prdata = (paddr == kto_pkg::REG_NODE_COUNT)
                  ? {{(kto_pkg::DATA_W-CW){1'b0}}, node_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= kto_pkg::NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr == kto_pkg::REG_NODE_COUNT) begin
      node_count <= pwdata[CW-1:0];
    end
  end

  always_comb begin
    priority if (node_count == '0) begin
      node_lim = CW'(1);
    end else if (node_count > CW'(MAX_NODES)) begin
      node_lim = CW'(MAX_NODES);
    end else begin
      node_lim = node_count;
    end
  end

  assign in_stall = !loading;
  assign accept = in_valid && loading;

  kto_loader #(.MAX_EDGES(MAX_EDGES), .EC_W(EC_W), .EA_W(EA_W)) u_loader (
    .clk(clk), .rst(rst), .accept(accept), .source_node(source_node),
    .target_node(target_node), .edge_present(edge_present), .node_lim(node_lim),
    .clear(clear), .rd_addr(rd_addr), .edge_total(edge_total),
    .rd_src(rd_src), .rd_dst(rd_dst)
  );

  kto_sorter #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES), .EC_W(EC_W), .EA_W(EA_W))
  u_sorter (
    .clk(clk), .rst(rst), .last_in(accept && last_edge), .node_lim(node_lim),
    .edge_total(edge_total), .rd_src(rd_src), .rd_dst(rd_dst), .rd_addr(rd_addr),
    .clear(clear), .loading(loading), .out_valid(out_valid), .out_stall(out_stall),
    .order_node(order_node), .cycle_found(cycle_found), .last_result(last_result)
  );
endmodule
